// ----- hdl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// shared types and constants of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGE_W  = 20;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 21;
  localparam int CMD_W   = 3;
  localparam int WORD_W  = 64;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_QPAGE = 3'd0,
    CMD_QADDR = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_RUN   = 3'd3,
    CMD_FIND  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ready;
    logic clr;
    logic mem_rd;
    logic mem_wr;
    logic step;
    logic restart;
    logic res_q;
    logic res_oor;
    logic res_acc;
    logic res_hit;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    cmd_t kind;
    logic clr_done;
    logic q_ok;
    logic run_ok;
    logic run_empty;
    logic last_word;
    logic free_nz;
    logic edge_hit;
    logic second;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/pba_ctrl.sv -----
// ----------------------------------------------------------------------------
// pba_ctrl
// sequencer for queries, run marking and the free page search
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pba_pkg::sts_t sts,
  output pba_pkg::ctl_t ctl
);
  import pba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.kind)
          CMD_QPAGE, CMD_QADDR: begin
            if (sts.q_ok) begin
              state_nxt = ST_READ;
            end else begin
              ctl.res_oor = 1'b1;
              state_nxt   = ST_DONE;
            end
          end
          CMD_MARK, CMD_RUN: begin
            if (sts.run_ok && !sts.run_empty) begin
              state_nxt = ST_READ;
            end else begin
              ctl.res_acc = sts.run_ok;
              state_nxt   = ST_DONE;
            end
          end
          CMD_FIND: state_nxt = ST_READ;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_READ: begin
        ctl.mem_rd = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        case (sts.kind)
          CMD_QPAGE, CMD_QADDR: begin
            ctl.res_q = 1'b1;
            state_nxt = ST_DONE;
          end
          CMD_MARK, CMD_RUN: begin
            ctl.mem_wr = 1'b1;
            if (sts.last_word) begin
              ctl.res_acc = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              ctl.step  = 1'b1;
              state_nxt = ST_READ;
            end
          end
          CMD_FIND: begin
            if (sts.free_nz) begin
              ctl.res_hit = 1'b1;
              state_nxt   = ST_DONE;
            end else if (sts.edge_hit) begin
              if (sts.second) begin
                state_nxt = ST_DONE;
              end else begin
                ctl.restart = 1'b1;
                state_nxt   = ST_READ;
              end
            end else begin
              ctl.step  = 1'b1;
              state_nxt = ST_READ;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/pba_datapath.sv -----
// ----------------------------------------------------------------------------
// pba_datapath
// usage bitmap memory, request registers, masks and result register
// ----------------------------------------------------------------------------
module pba_datapath #(
  parameter int PAGE_COUNT = 1048576,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [pba_pkg::CMD_W-1:0] in_user,
  input  logic [pba_pkg::IN_W-1:0]  in_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [pba_pkg::OUT_W-1:0] out_data,
  input  pba_pkg::ctl_t             ctl,
  output pba_pkg::sts_t             sts
);
  import pba_pkg::*;

  localparam int WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int QW    = (ADDR_W - PAGE_SHIFT > PAGE_W) ? ADDR_W - PAGE_SHIFT : PAGE_W;
  localparam int LASTN = PAGE_COUNT - (WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK =
    (LASTN == WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << LASTN) - 64'd1);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  logic [WORD_W-1:0] mem [WORDS];

  // input fields
  logic [CMD_W-1:0]   f_cmd;
  logic [PAGE_W-1:0]  f_page;
  logic [ADDR_W-1:0]  f_addr;
  logic [COUNT_W-1:0] f_count;
  logic               f_used;

  assign f_cmd   = in_user;
  assign f_page  = in_data[19:0];
  assign f_addr  = in_data[51:20];
  assign f_count = in_data[72:52];
  assign f_used  = in_data[73];

  logic               accept;
  logic [QW-1:0]      qpage;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W:0]   endp;
  logic [WAW-1:0]     lf_w;
  logic [WAW-1:0]     start;

  assign accept = ctl.ready & in_valid;
  assign qpage  = (cmd_t'(f_cmd) == CMD_QADDR) ? QW'(f_addr >> PAGE_SHIFT) : QW'(f_page);
  assign cnt    = (cmd_t'(f_cmd) == CMD_MARK) ? COUNT_W'(1) : f_count;
  assign sum    = (COUNT_W+1)'(f_page) + (COUNT_W+1)'(cnt);
  assign endp   = sum - (COUNT_W+1)'(1);

  logic [PAGE_W-1:0]  last_found_r;
  logic               dir_r;
  logic               second_r;
  logic [CMD_W-1:0]   kind_r;
  logic               qok_r, runok_r, empty_r, used_r;
  logic [WAW-1:0]     cur_r, first_r, lastw_r, start_r, clr_r;
  logic [5:0]         off_r, loff_r;
  logic [WORD_W-1:0]  rd_r;
  logic               res_acc_r, res_inuse_r, res_found_r;
  logic [PAGE_W-1:0]  res_page_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  assign lf_w  = last_found_r[WAW+5:6];
  assign start = (lf_w > LAST_WORD) ? LAST_WORD : lf_w;

  // run mask and free bits of the current word
  logic [WORD_W-1:0] mask, freebits, wr_word;
  logic [5:0]        lo, hi, idx;

  always_comb begin
    lo = (cur_r == first_r) ? off_r : 6'd0;
    hi = (cur_r == lastw_r) ? loff_r : 6'd63;
    for (int i = 0; i < WORD_W; i++) begin
      mask[i] = (6'(i) >= lo) && (6'(i) <= hi);
    end
    wr_word  = used_r ? (rd_r | mask) : (rd_r & ~mask);
    freebits = ~rd_r & ((cur_r == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
    idx = 6'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (freebits[i]) idx = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[clr_r] <= '0;
    end else if (ctl.mem_wr) begin
      mem[cur_r] <= wr_word;
    end
    if (ctl.mem_rd) rd_r <= mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      last_found_r <= '0;
      dir_r        <= 1'b0;
      second_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.clr) clr_r <= clr_r + WAW'(1);
      if (accept) second_r <= 1'b0;
      if (ctl.restart) begin
        dir_r    <= ~dir_r;
        second_r <= 1'b1;
      end
      if (ctl.res_hit) last_found_r <= PAGE_W'({cur_r, idx});
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= f_cmd;
      qok_r   <= (33'(qpage) < 33'(PAGE_COUNT));
      runok_r <= ((COUNT_W+1)'(f_page) < (COUNT_W+1)'(PAGE_COUNT)) &&
                 (sum <= (COUNT_W+1)'(PAGE_COUNT));
      empty_r <= (cnt == '0);
      used_r  <= f_used;
      first_r <= f_page[WAW+5:6];
      lastw_r <= endp[WAW+5:6];
      loff_r  <= endp[5:0];
      start_r <= start;
      case (cmd_t'(f_cmd))
        CMD_QPAGE, CMD_QADDR: begin
          cur_r <= qpage[WAW+5:6];
          off_r <= qpage[5:0];
        end
        CMD_FIND: begin
          cur_r <= start;
          off_r <= f_page[5:0];
        end
        default: begin
          cur_r <= f_page[WAW+5:6];
          off_r <= f_page[5:0];
        end
      endcase
      res_acc_r   <= 1'b0;
      res_inuse_r <= 1'b0;
      res_found_r <= 1'b0;
      res_page_r  <= '0;
    end else begin
      if (ctl.restart) begin
        cur_r <= start_r;
      end else if (ctl.step) begin
        if (cmd_t'(kind_r) == CMD_FIND && dir_r) begin
          cur_r <= cur_r - WAW'(1);
        end else begin
          cur_r <= cur_r + WAW'(1);
        end
      end
      if (ctl.res_q) begin
        res_acc_r   <= 1'b1;
        res_inuse_r <= rd_r[off_r];
      end
      if (ctl.res_oor) res_inuse_r <= 1'b1;
      if (ctl.res_acc) res_acc_r <= 1'b1;
      if (ctl.res_hit) begin
        res_acc_r   <= 1'b1;
        res_found_r <= 1'b1;
        res_page_r  <= PAGE_W'({cur_r, idx});
      end
    end
    if (ctl.out_load) begin
      out_data_r <= {1'b0, res_found_r, res_page_r, res_inuse_r, res_acc_r};
    end
  end

  assign sts.kind      = cmd_t'(kind_r);
  assign sts.clr_done  = (clr_r == LAST_WORD);
  assign sts.q_ok      = qok_r;
  assign sts.run_ok    = runok_r;
  assign sts.run_empty = empty_r;
  assign sts.last_word = (cur_r == lastw_r);
  assign sts.free_nz   = (freebits != '0);
  assign sts.edge_hit  = dir_r ? (cur_r == '0) : (cur_r == LAST_WORD);
  assign sts.second    = second_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/page_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// one bit per page usage bitmap with queries, run marking and next-fit search
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+--------------------------------
//  input    | in_tvalid/tready/tuser/tdata   | one request: command and operands
//  result   | out_tvalid/tready/tdata        | one result for every request
//
//  a query reads one bitmap word, a run reads and writes back each 64-page word
//  it touches, and a search reads group after group, from the start group to one
//  end and then from it to the other, one word at a time on the single memory port
//  after reset a clearing pass writes one word a cycle, through every bitmap word,
//  before the first request is taken
//  a new request is taken while the previous result waits on out_tready
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int PAGE_COUNT = 1048576,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // command[2:0]
  input  logic [pba_pkg::CMD_W-1:0] in_tuser,
  // page[19:0] address[51:20] count[72:52] mark_used[73]
  input  logic [pba_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // accepted[0] in_use[1] found_page[21:2] found[22]
  output logic [pba_pkg::OUT_W-1:0] out_tdata
);
  import pba_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign in_tready = ctl.ready;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .sts      (sts),
    .ctl      (ctl)
  );

  pba_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_user   (in_tuser),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

// ----- dv/page_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// streams directed and random requests into the allocator with random gaps on
// both sides, predicts every result from a local copy of the usage bitmap and
// the next-fit search state, and compares the results field by field
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
  import pba_pkg::*;

  localparam int PAGES     = 1048576;
  localparam int WORDS     = PAGES / 64;
  localparam int N_RANDOM  = 400;
  localparam int CYC_LIMIT = 150000000;

  typedef struct {
    logic [2:0]  cmd;
    logic [19:0] page;
    logic [31:0] addr;
    logic [20:0] count;
    logic        used;
  } req_t;

  typedef struct {
    logic        acc;
    logic        in_use;
    logic [19:0] fpage;
    logic        found;
  } res_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [CMD_W-1:0] in_tuser = '0;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  bit [63:0]   usage_words [WORDS];
  logic [19:0] last_page = '0;
  bit          downward = 0;

  res_t pending_q[$];
  res_t typed_q[$];
  bit   typed_flag_q[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_got = 0;
  int   cycles = 0;
  bit   hold_long = 0;
  bit   send_done = 0;
  row_t rows[$];

  page_bitmap_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit page_bit(int unsigned pg);
    return usage_words[pg >> 6][pg & 63];
  endfunction

  function automatic res_t alloc_predict(req_t r);
    res_t o;
    int unsigned pg;
    int g, start;
    bit second;
    bit [63:0] fr;
    o = '{default: '0};
    case (r.cmd)
      CMD_QPAGE, CMD_QADDR: begin
        pg = (r.cmd == CMD_QPAGE) ? r.page : (r.addr >> 12);
        o.acc = pg < PAGES;
        o.in_use = (pg < PAGES) ? page_bit(pg) : 1'b1;
      end
      CMD_MARK: begin
        usage_words[r.page >> 6][r.page & 63] = r.used;
        o.acc = 1;
      end
      CMD_RUN: begin
        if (longint'(r.page) + longint'(r.count) <= PAGES) begin
          for (int unsigned p = r.page; p < r.page + r.count; p++)
            usage_words[p >> 6][p & 63] = r.used;
          o.acc = 1;
        end
      end
      CMD_FIND: begin
        start = int'(last_page >> 6);
        g = start;
        second = 0;
        forever begin
          fr = ~usage_words[g];
          if (fr != 0) begin
            for (int i = 63; i >= 0; i--)
              if (fr[i]) pg = g * 64 + i;
            last_page = pg[19:0];
            o.acc = 1;
            o.found = 1;
            o.fpage = pg[19:0];
            break;
          end
          g += downward ? -1 : 1;
          if (g < 0 || g >= WORDS) begin
            if (second) break;
            downward = !downward;
            second = 1;
            g = start;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic row_t mk(logic [2:0] c, logic [19:0] p, logic [31:0] a,
                              logic [20:0] n, logic u);
    row_t w;
    w.req = '{c, p, a, n, u};
    w.typed = 0;
    w.res = '{default: '0};
    return w;
  endfunction

  function automatic row_t mkx(row_t w, logic acc, logic iu, logic [19:0] fp, logic f);
    w.typed = 1;
    w.res = '{acc, iu, fp, f};
    return w;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.page  = 20'($urandom);
    r.addr  = $urandom;
    r.count = 21'($urandom_range(0, 200));
    r.used  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1)) r.page = 20'($urandom_range(0, 2047));
    k = $urandom_range(0, 99);
    if (k < 12) r.cmd = CMD_QPAGE;
    else if (k < 22) r.cmd = CMD_QADDR;
    else if (k < 50) r.cmd = CMD_MARK;
    else if (k < 70) begin
      r.cmd = CMD_RUN;
      if ($urandom_range(0, 19) == 0) r.count = 21'($urandom);
    end else if (k < 97) r.cmd = CMD_FIND;
    else r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // prediction at input handshake, comparison at result handshake
  always @(posedge clk) begin
    res_t e, x, a;
    req_t r;
    bit t;
    if (rst_n) cycles <= cycles + 1;
    if (in_tvalid && in_tready) begin
      r.cmd   = in_tuser;
      r.page  = in_tdata[19:0];
      r.addr  = in_tdata[51:20];
      r.count = in_tdata[72:52];
      r.used  = in_tdata[73];
      pending_q.push_back(alloc_predict(r));
    end
    if (out_tvalid && out_tready) begin
      a = '{out_tdata[0], out_tdata[1], out_tdata[21:2], out_tdata[22]};
      n_got++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request waiting, got %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        t = typed_flag_q.pop_front();
        x = typed_q.pop_front();
        if (t && x != e) begin
          $display("%0t: table row expected %p predictor %p", $time, x, e);
          errors++;
        end
        if (a.acc !== e.acc) begin
          $display("%0t: accepted expected %0d actual %0d", $time, e.acc, a.acc);
          errors++;
        end
        if (a.in_use !== e.in_use) begin
          $display("%0t: in_use expected %0d actual %0d", $time, e.in_use, a.in_use);
          errors++;
        end
        if (a.fpage !== e.fpage) begin
          $display("%0t: found_page expected %h actual %h", $time, e.fpage, a.fpage);
          errors++;
        end
        if (a.found !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $time, e.found, a.found);
          errors++;
        end
      end
    end
  end

  // result side
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_req(req_t r, bit t, res_t x);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    typed_flag_q.push_back(t);
    typed_q.push_back(x);
    in_tvalid <= 1;
    in_tuser  <= r.cmd;
    in_tdata  <= {6'b0, r.used, r.count, r.addr, r.page};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // request side
  initial begin
    res_t none;
    none = '{default: '0};
    rows.push_back(mkx(mk(CMD_QPAGE, 20'h0, 0, 0, 0), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_QPAGE, 20'hFFFFF, 0, 0, 1), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_QADDR, 0, 32'hFFFFFFFF, 0, 0), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_QADDR, 0, 32'h0, 21'h1FFFFF, 1), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_MARK, 20'hFFFFF, 0, 0, 1), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_QPAGE, 20'hFFFFF, 0, 0, 0), 1, 1, 0, 0));
    rows.push_back(mkx(mk(CMD_RUN, 20'h0, 0, 0, 1), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_RUN, 20'h1, 0, 21'd1048576, 1), 0, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_RUN, 20'hFFFFF, 0, 21'd2, 1), 0, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_RUN, 20'hFFFFF, 0, 21'd1, 0), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_FIND, 0, 0, 0, 0), 1, 0, 0, 1));
    rows.push_back(mk(CMD_RUN, 20'h0, 0, 21'd130, 1));
    rows.push_back(mk(CMD_FIND, 0, 0, 0, 0));
    rows.push_back(mk(CMD_RUN, 20'd65, 0, 21'd3, 0));
    rows.push_back(mk(CMD_FIND, 0, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_RUN, 20'h0, 0, 21'd1048576, 1), 1, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_FIND, 0, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_QADDR, 0, 32'h12345678, 0, 0), 1, 1, 0, 0));
    rows.push_back(mk(CMD_MARK, 20'd7, 0, 0, 0));
    rows.push_back(mk(CMD_FIND, 0, 0, 0, 0));
    rows.push_back(mkx(mk(CMD_RUN, 20'h0, 0, 21'd1048576, 0), 1, 0, 0, 0));
    rows.push_back(mk(CMD_FIND, 0, 0, 0, 0));
    rows.push_back(mkx(mk(3'd5, 20'hFFFFF, 32'hFFFFFFFF, 21'h1FFFFF, 1), 0, 0, 0, 0));
    rows.push_back(mkx(mk(3'd7, 0, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(mk(CMD_FIND, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) hold_long = 1;
      if (i == 250) begin
        in_tvalid <= 0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end
      send_req(rand_req(), 0, none);
    end
    in_tvalid <= 0;
    send_done = 1;
  end

  // end of run and timeout
  initial begin
    fork
      begin
        wait (send_done && pending_q.size() == 0);
        repeat (200) @(posedge clk);
      end
      wait (cycles >= CYC_LIMIT);
    join_any
    $display("sent %0d requests (directed table, then random mix of queries,", n_sent);
    $display("marks, runs, finds and unknown commands); %0d results checked", n_got);
    if (cycles >= CYC_LIMIT || pending_q.size() != 0) begin
      $display("timeout or missing results after %0d cycles", cycles);
      $display("page_bitmap_allocator_tb: done, errors");
    end else if (errors == 0) begin
      $display("page_bitmap_allocator_tb: done, clean");
    end else begin
      $display("page_bitmap_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pba_pkg.sv
hdl/pba_ctrl.sv
hdl/pba_datapath.sv
hdl/page_bitmap_allocator.sv
dv/page_bitmap_allocator_tb.sv
